>>> rtl/ffh_pkg.sv
// Package: shared constants, opcodes, controller/datapath command and status types.
package ffh_pkg;
  localparam int MAX_SIDE    = 256;
  localparam int HEIGHT_BITS = 24;
  localparam int COORD_BITS  = $clog2(MAX_SIDE);
  localparam int SIDE_BITS   = COORD_BITS + 1;
  localparam int ADDR_BITS   = 2 * COORD_BITS;
  localparam int CELLS       = MAX_SIDE * MAX_SIDE;
  localparam int CNT_BITS    = 16;
  localparam int DIV_BITS    = CNT_BITS + HEIGHT_BITS + 2;

  localparam logic [1:0] OP_FAULT  = 2'd0;
  localparam logic [1:0] OP_SMOOTH = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;
  localparam logic [1:0] OP_CLEAR  = 2'd3;

  localparam logic [2:0] REG_SIZE   = 3'd0;
  localparam logic [2:0] REG_FAULTS = 3'd1;
  localparam logic [2:0] REG_MIN    = 3'd2;
  localparam logic [2:0] REG_MAX    = 3'd3;
  localparam logic [2:0] REG_COEFF  = 3'd4;

  // sweep kinds
  localparam logic [2:0] SW_FAULT = 3'd0;
  localparam logic [2:0] SW_LR    = 3'd1;
  localparam logic [2:0] SW_RL    = 3'd2;
  localparam logic [2:0] SW_TB    = 3'd3;
  localparam logic [2:0] SW_BT    = 3'd4;
  localparam logic [2:0] SW_CLEAR = 3'd5;

  typedef struct packed {
    logic       latch;      // capture input item
    logic       div_start;
    logic       sweep_start;
    logic [2:0] sweep_kind;
    logic       read_start;
    logic       count_fault;
    logic       clear_count;
    logic       post;       // load result register
  } ffh_cmd_t;

  typedef struct packed {
    logic div_done;
    logic sweep_done;
    logic read_done;
  } ffh_sts_t;
endpackage

>>> rtl/ffh_if.sv
// Interfaces: input item channel and result channel.
interface ffh_in_if;
  import ffh_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [1:0]            operation;
  logic [COORD_BITS-1:0] first_x;
  logic [COORD_BITS-1:0] first_z;
  logic [COORD_BITS-1:0] second_x;
  logic [COORD_BITS-1:0] second_z;
  logic [COORD_BITS-1:0] cell_x;
  logic [COORD_BITS-1:0] cell_z;
  modport source (output valid, operation, first_x, first_z, second_x, second_z,
                  cell_x, cell_z, input ready);
  modport sink (input valid, operation, first_x, first_z, second_x, second_z,
                cell_x, cell_z, output ready);
endinterface

interface ffh_out_if;
  import ffh_pkg::*;
  logic                          valid;
  logic                          ready;
  logic signed [HEIGHT_BITS-1:0] height_value;
  logic                          saturated;
  modport source (output valid, height_value, saturated, input ready);
  modport sink (input valid, height_value, saturated, output ready);
endinterface

>>> rtl/ffh_ctrl.sv
// Controller: sequences fault, smooth, read and clear operations.
module ffh_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_operation,
  input  logic              res_busy,
  input  ffh_pkg::ffh_sts_t sts,
  output ffh_pkg::ffh_cmd_t cmd
);
  import ffh_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECODE = 4'd1;
  localparam logic [3:0] S_DIV    = 4'd2;
  localparam logic [3:0] S_FAULT  = 4'd3;
  localparam logic [3:0] S_LR     = 4'd4;
  localparam logic [3:0] S_RL     = 4'd5;
  localparam logic [3:0] S_TB     = 4'd6;
  localparam logic [3:0] S_BT     = 4'd7;
  localparam logic [3:0] S_READ   = 4'd8;
  localparam logic [3:0] S_CLEAR  = 4'd9;
  localparam logic [3:0] S_POST   = 4'd10;
  localparam logic [3:0] S_WAIT   = 4'd11;

  logic [3:0] state_r, state_nxt;
  logic [1:0] op_r, op_nxt;
  logic       first_r, first_nxt;   // sweep start pulse pending

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    first_nxt = 1'b0;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          op_nxt    = in_operation;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        first_nxt = 1'b1;
        unique case (op_r)
          OP_FAULT: begin
            cmd.div_start = 1'b1;
            first_nxt     = 1'b0;
            state_nxt     = S_DIV;
          end
          OP_SMOOTH: state_nxt = S_LR;
          OP_READ: begin
            cmd.read_start = 1'b1;
            first_nxt      = 1'b0;
            state_nxt      = S_READ;
          end
          default: state_nxt = S_CLEAR;
        endcase
      end
      S_DIV: begin
        if (sts.div_done) begin
          first_nxt = 1'b1;
          state_nxt = S_FAULT;
        end
      end
      S_FAULT, S_LR, S_RL, S_TB, S_BT, S_CLEAR: begin
        if (first_r) begin
          cmd.sweep_start = 1'b1;
          unique case (state_r)
            S_FAULT: cmd.sweep_kind = SW_FAULT;
            S_LR:    cmd.sweep_kind = SW_LR;
            S_RL:    cmd.sweep_kind = SW_RL;
            S_TB:    cmd.sweep_kind = SW_TB;
            S_BT:    cmd.sweep_kind = SW_BT;
            default: cmd.sweep_kind = SW_CLEAR;
          endcase
        end else if (sts.sweep_done) begin
          first_nxt = 1'b1;
          unique case (state_r)
            S_LR: state_nxt = S_RL;
            S_RL: state_nxt = S_TB;
            S_TB: state_nxt = S_BT;
            S_FAULT: begin
              cmd.count_fault = 1'b1;
              first_nxt       = 1'b0;
              state_nxt       = S_POST;
            end
            S_CLEAR: begin
              cmd.clear_count = 1'b1;
              first_nxt       = 1'b0;
              state_nxt       = S_POST;
            end
            default: begin
              first_nxt = 1'b0;
              state_nxt = S_POST;
            end
          endcase
        end
      end
      S_READ: begin
        if (sts.read_done) state_nxt = S_POST;
      end
      S_POST: begin
        if (!res_busy) begin
          cmd.post  = 1'b1;
          state_nxt = S_WAIT;
        end
      end
      S_WAIT: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      op_r    <= OP_FAULT;
      first_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
      first_r <= first_nxt;
    end
  end
endmodule

>>> rtl/ffh_div.sv
// Restoring divider for the per-fault height step: k*(max-min)/iters, truncating.
module ffh_div (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  logic signed [ffh_pkg::DIV_BITS-1:0]  dividend,
  input  logic        [ffh_pkg::CNT_BITS-1:0]  divisor,
  output logic                                 done,
  output logic signed [ffh_pkg::DIV_BITS-1:0]  quotient
);
  import ffh_pkg::*;
  localparam int STEP_BITS = $clog2(DIV_BITS + 1);

  logic [DIV_BITS-1:0]  q_r, q_nxt;
  logic [CNT_BITS:0]    rem_r, rem_nxt;
  logic [STEP_BITS-1:0] cnt_r, cnt_nxt;
  logic                 neg_r, neg_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [CNT_BITS:0]    shifted;
  logic [CNT_BITS:0]    diff;

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    neg_nxt  = neg_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    shifted  = {rem_r[CNT_BITS-1:0], q_r[DIV_BITS-1]};
    diff     = shifted - {1'b0, divisor};
    if (start) begin
      neg_nxt  = dividend[DIV_BITS-1];
      q_nxt    = dividend[DIV_BITS-1] ? DIV_BITS'(-dividend) : dividend;
      rem_nxt  = '0;
      cnt_nxt  = STEP_BITS'(DIV_BITS);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!diff[CNT_BITS]) begin
        rem_nxt = diff;
        q_nxt   = {q_r[DIV_BITS-2:0], 1'b1};
      end else begin
        rem_nxt = shifted;
        q_nxt   = {q_r[DIV_BITS-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - STEP_BITS'(1);
      if (cnt_r == STEP_BITS'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  assign done     = done_r;
  assign quotient = neg_r ? -$signed(q_r) : $signed(q_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
    neg_r <= neg_nxt;
  end
endmodule

>>> rtl/ffh_dp.sv
// Datapath: height map memory, cell sweep, fault adder, smoothing filter, counter.
module ffh_dp (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  ffh_pkg::ffh_cmd_t                      cmd,
  output ffh_pkg::ffh_sts_t                      sts,
  input  logic [ffh_pkg::COORD_BITS-1:0]         first_x,
  input  logic [ffh_pkg::COORD_BITS-1:0]         first_z,
  input  logic [ffh_pkg::COORD_BITS-1:0]         second_x,
  input  logic [ffh_pkg::COORD_BITS-1:0]         second_z,
  input  logic [ffh_pkg::COORD_BITS-1:0]         cell_x,
  input  logic [ffh_pkg::COORD_BITS-1:0]         cell_z,
  input  logic [ffh_pkg::SIDE_BITS-1:0]          terrain_size,
  input  logic [ffh_pkg::CNT_BITS-1:0]           fault_count,
  input  logic signed [ffh_pkg::HEIGHT_BITS-1:0] min_height,
  input  logic signed [ffh_pkg::HEIGHT_BITS-1:0] max_height,
  input  logic [8:0]                             smooth_coeff,
  output logic signed [ffh_pkg::HEIGHT_BITS-1:0] res_height,
  output logic                                   res_sat
);
  import ffh_pkg::*;
  localparam int HB  = HEIGHT_BITS;
  localparam int CB  = COORD_BITS;
  localparam int CPB = 2 * CB + 4;   // cross product width
  localparam int MB  = HB + 10;      // filter product width
  localparam logic signed [HB-1:0] HMAX = {1'b0, {(HB-1){1'b1}}};
  localparam logic signed [HB-1:0] HMIN = {1'b1, {(HB-1){1'b0}}};

  // map memory: written and read in one clocked block, one port each
  logic [HB-1:0] mem [CELLS];
  logic [HB-1:0] rd_data_r;
  logic [ADDR_BITS-1:0] rd_addr;
  logic          wr_en;
  logic [ADDR_BITS-1:0] wr_addr;
  logic [HB-1:0] wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data_r <= mem[rd_addr];
  end

  // captured item
  logic [CB-1:0] p1x_r, p1z_r, p2x_r, p2z_r, cx_r, cz_r;
  logic [CB:0]   n_r;
  logic [8:0]    f_r;
  logic [CNT_BITS-1:0] iters_r;
  logic [CNT_BITS-1:0] faults_r, faults_nxt;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      p1x_r <= first_x;
      p1z_r <= first_z;
      p2x_r <= second_x;
      p2z_r <= second_z;
      cx_r  <= cell_x;
      cz_r  <= cell_z;
      n_r   <= (terrain_size < SIDE_BITS'(2)) ? SIDE_BITS'(2) :
               (terrain_size > SIDE_BITS'(MAX_SIDE)) ? SIDE_BITS'(MAX_SIDE) : terrain_size;
      f_r   <= (smooth_coeff > 9'd256) ? 9'd256 : smooth_coeff;
      iters_r <= (fault_count == '0) ? CNT_BITS'(1) : fault_count;
    end
  end

  // fault height: k*(max-min) registered, divided, then max - q clamped
  logic signed [HB:0]         span_r;
  logic signed [DIV_BITS-1:0] prod_r;
  logic [CNT_BITS-1:0]        k_c;
  logic                       div_go_r;
  logic                       div_done;
  logic signed [DIV_BITS-1:0] quot;
  logic signed [HB-1:0]       h_r;
  logic signed [DIV_BITS-1:0] hwide;

  assign k_c = (faults_r > iters_r - CNT_BITS'(1)) ? iters_r - CNT_BITS'(1) : faults_r;

  always_ff @(posedge clk) begin
    if (cmd.div_start) span_r <= (HB+1)'(max_height) - (HB+1)'(min_height);
    prod_r <= DIV_BITS'($signed({1'b0, k_c}) * span_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) div_go_r <= 1'b0;
    else        div_go_r <= cmd.div_start;
  end

  logic div_go2_r;
  always_ff @(posedge clk) begin
    if (!rst_n) div_go2_r <= 1'b0;
    else        div_go2_r <= div_go_r;
  end

  ffh_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_go2_r),
    .dividend (prod_r),
    .divisor  (iters_r),
    .done     (div_done),
    .quotient (quot)
  );

  assign hwide = DIV_BITS'(max_height) - quot;

  always_ff @(posedge clk) begin
    if (div_done) begin
      if (hwide > DIV_BITS'(HMAX)) begin
        h_r <= HMAX;
      end else if (hwide < DIV_BITS'(HMIN)) begin
        h_r <= HMIN;
      end else begin
        h_r <= HB'(hwide);
      end
    end
  end

  // sweep: outer line a, inner position b; stage 0 address issue, stage 1 compute+write
  logic [2:0]    kind_r;
  logic          run_r;
  logic [CB:0]   a_r, b_r;
  logic          line_first_r;   // first cell of a line: loads prev
  logic          v1_r;           // stage 1 valid
  logic          v1_first_r;
  logic [CB-1:0] x1_r, z1_r;
  logic signed [HB-1:0] prev_r;
  logic          sat_r;
  logic          sweep_done_r;
  logic [CB-1:0] xs, zs;
  logic [CB:0]   last;
  logic [CB:0]   b_start;

  assign last = n_r - (CB+1)'(1);
  always_comb begin
    // smoothing passes start on the line's first cell, which only loads prev
    unique case (kind_r)
      SW_RL, SW_BT: b_start = last;
      default:      b_start = '0;
    endcase
    unique case (kind_r)
      SW_TB, SW_BT: begin xs = CB'(a_r); zs = CB'(b_r); end
      default:      begin xs = CB'(b_r); zs = CB'(a_r); end
    endcase
  end

  logic line_end;
  assign line_end = (kind_r == SW_RL || kind_r == SW_BT) ? (b_r == '0) : (b_r == last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r        <= 1'b0;
      v1_r         <= 1'b0;
      sweep_done_r <= 1'b0;
    end else begin
      sweep_done_r <= 1'b0;
      if (cmd.sweep_start) begin
        run_r        <= 1'b1;
        a_r          <= '0;
        line_first_r <= 1'b1;
        b_r          <= (cmd.sweep_kind == SW_RL || cmd.sweep_kind == SW_BT) ? last : '0;
      end else if (run_r) begin
        line_first_r <= 1'b0;
        if (line_end) begin
          line_first_r <= 1'b1;
          b_r <= b_start;
          a_r <= a_r + (CB+1)'(1);
          if (a_r == last) run_r <= 1'b0;
        end else if (kind_r == SW_RL || kind_r == SW_BT) begin
          b_r <= b_r - (CB+1)'(1);
        end else begin
          b_r <= b_r + (CB+1)'(1);
        end
      end
      v1_r <= run_r;
      if (v1_r && !run_r) sweep_done_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sweep_start) kind_r <= cmd.sweep_kind;
    x1_r       <= xs;
    z1_r       <= zs;
    v1_first_r <= line_first_r;
  end

  // stage 1 arithmetic
  logic signed [CPB-1:0] dx, dz, cp;
  logic signed [HB:0]    fsum;
  logic signed [MB-1:0]  mix;
  logic signed [HB-1:0]  sval;
  logic signed [HB-1:0]  cur;

  assign cur = $signed(rd_data_r);
  always_comb begin
    dx   = CPB'($signed({1'b0, p2x_r})) - CPB'($signed({1'b0, p1x_r}));
    dz   = CPB'($signed({1'b0, p2z_r})) - CPB'($signed({1'b0, p1z_r}));
    cp   = CPB'((CPB'($signed({1'b0, x1_r})) - CPB'($signed({1'b0, p1x_r}))) * dz)
         - CPB'((CPB'($signed({1'b0, z1_r})) - CPB'($signed({1'b0, p1z_r}))) * dx);
    fsum = (HB+1)'(cur) + (HB+1)'(h_r);
    mix  = MB'($signed({1'b0, f_r}) * prev_r)
         + MB'($signed({1'b0, 9'd256 - f_r}) * cur);
    sval = HB'(mix >>> 8);
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = {z1_r, x1_r};
    wr_data = rd_data_r;
    if (v1_r) begin
      unique case (kind_r)
        SW_FAULT: begin
          wr_en = (cp > 0);
          if (fsum > (HB+1)'(HMAX))      wr_data = HMAX;
          else if (fsum < (HB+1)'(HMIN)) wr_data = HMIN;
          else                           wr_data = HB'(fsum);
        end
        SW_CLEAR: begin
          wr_en   = 1'b1;
          wr_data = '0;
        end
        default: begin
          wr_en   = !v1_first_r;
          wr_data = sval;
        end
      endcase
    end
  end

  // read port: sweep address or single cell read
  logic rd_pend_r, rd_pend2_r, read_done_r;
  assign rd_addr = run_r ? {zs, xs} : {cz_r, cx_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_pend_r   <= 1'b0;
      rd_pend2_r  <= 1'b0;
      read_done_r <= 1'b0;
    end else begin
      rd_pend_r   <= cmd.read_start;
      rd_pend2_r  <= rd_pend_r;
      read_done_r <= rd_pend2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) sat_r <= 1'b0;
    else if (v1_r && kind_r == SW_FAULT && cp > 0 &&
             (fsum > (HB+1)'(HMAX) || fsum < (HB+1)'(HMIN))) sat_r <= 1'b1;
    else if (div_done && (hwide > DIV_BITS'(HMAX) || hwide < DIV_BITS'(HMIN)))
      sat_r <= 1'b1;
    if (v1_r && kind_r != SW_FAULT && kind_r != SW_CLEAR)
      prev_r <= v1_first_r ? cur : sval;
    if (rd_pend2_r) res_height <= cur;
  end

  assign res_sat = sat_r;

  // fault counter
  always_comb begin
    faults_nxt = faults_r;
    if (cmd.clear_count) faults_nxt = '0;
    else if (cmd.count_fault && faults_r != '1) faults_nxt = faults_r + CNT_BITS'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) faults_r <= '0;
    else        faults_r <= faults_nxt;
  end

  assign sts.div_done   = div_done;
  assign sts.sweep_done = sweep_done_r;
  assign sts.read_done  = read_done_r;
endmodule

>>> rtl/fault_formation_heightmap.sv
// Top level: fault-formation height map with APB configuration.
//  channel | dir | handshake     | payload
//  in_     | in  | valid/ready   | operation, fault points, read cell
//  out_    | out | valid/ready   | height_value, saturated
//  cfg_    | in  | APB psel/pen  | 5 registers at 4*i
// Fault and smooth sweep the used n x n square one cell per cycle, read then write
// through one memory port pair; clear sweeps the whole MAX_SIDE x MAX_SIDE map.
// A fault operation runs a 42-step divide before its sweep; smooth sweeps the square
// left-right, right-left, top-bottom and bottom-top.
// After reset the same clear pass runs first; no item is taken meanwhile.
// One item at a time; out_ holds a result until taken, and the next result waits for that.
module fault_formation_heightmap (
  input  logic        clk,
  input  logic        rst_n,
  ffh_in_if.sink      in_ch,
  ffh_out_if.source   out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import ffh_pkg::*;

  logic [SIDE_BITS-1:0]   size_r;
  logic [CNT_BITS-1:0]    fcount_r;
  logic [HEIGHT_BITS-1:0] minh_r, maxh_r;
  logic [8:0]             coeff_r;
  logic [2:0]             reg_idx;
  logic                   wr;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[4:2];
  assign wr         = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r   <= SIDE_BITS'(MAX_SIDE);
      fcount_r <= CNT_BITS'(100);
      minh_r   <= '0;
      maxh_r   <= HEIGHT_BITS'(25600);
      coeff_r  <= 9'd128;
    end else if (wr && cfg_paddr[1:0] == 2'b00) begin
      unique case (reg_idx)
        REG_SIZE:   size_r   <= cfg_pwdata[SIDE_BITS-1:0];
        REG_FAULTS: fcount_r <= cfg_pwdata[CNT_BITS-1:0];
        REG_MIN:    minh_r   <= cfg_pwdata[HEIGHT_BITS-1:0];
        REG_MAX:    maxh_r   <= cfg_pwdata[HEIGHT_BITS-1:0];
        REG_COEFF:  coeff_r  <= cfg_pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_SIZE:   cfg_prdata = 32'(size_r);
      REG_FAULTS: cfg_prdata = 32'(fcount_r);
      REG_MIN:    cfg_prdata = 32'(minh_r);
      REG_MAX:    cfg_prdata = 32'(maxh_r);
      REG_COEFF:  cfg_prdata = 32'(coeff_r);
      default:    cfg_prdata = '0;
    endcase
  end

  // post-reset clearing pass, reusing the clear operation
  logic init_r;
  logic boot_r;
  logic                   ctrl_valid;
  logic                   ctrl_ready;
  logic [1:0]             ctrl_op;
  ffh_cmd_t               cmd;
  ffh_sts_t               sts;
  logic                   out_valid_r;
  logic signed [HEIGHT_BITS-1:0] out_h_r;
  logic                   out_sat_r;
  logic [1:0]             op_r;
  logic signed [HEIGHT_BITS-1:0] dp_h;
  logic                   dp_sat;
  logic                   rd_ok;

  assign ctrl_valid  = init_r ? 1'b1 : in_ch.valid;
  assign ctrl_op     = init_r ? OP_CLEAR : in_ch.operation;
  assign in_ch.ready = ctrl_ready && !init_r;

  ffh_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (ctrl_valid),
    .in_ready     (ctrl_ready),
    .in_operation (ctrl_op),
    .res_busy     (out_valid_r),
    .sts          (sts),
    .cmd          (cmd)
  );

  // clear always covers the whole map
  ffh_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .first_x      (in_ch.first_x),
    .first_z      (in_ch.first_z),
    .second_x     (in_ch.second_x),
    .second_z     (in_ch.second_z),
    .cell_x       (in_ch.cell_x),
    .cell_z       (in_ch.cell_z),
    .terrain_size ((ctrl_op == OP_CLEAR) ? SIDE_BITS'(MAX_SIDE) : size_r),
    .fault_count  (fcount_r),
    .min_height   (minh_r),
    .max_height   (maxh_r),
    .smooth_coeff (coeff_r),
    .res_height   (dp_h),
    .res_sat      (dp_sat)
  );

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r <= ctrl_op;
    end
  end

  function automatic logic [SIDE_BITS-1:0] u_n();
    if (size_r < SIDE_BITS'(2)) return SIDE_BITS'(2);
    if (size_r > SIDE_BITS'(MAX_SIDE)) return SIDE_BITS'(MAX_SIDE);
    return size_r;
  endfunction

  // terrain size is to change only while idle (the block does not enforce it); range check is taken at latch
  assign rd_ok = ({1'b0, in_ch.cell_x} < u_n()) && ({1'b0, in_ch.cell_z} < u_n());

  logic rd_ok_r;
  always_ff @(posedge clk) begin
    if (cmd.latch) rd_ok_r <= rd_ok;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_r      <= 1'b1;
      boot_r      <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.latch) boot_r <= init_r;
      if (cmd.post && boot_r) init_r <= 1'b0;
      if (cmd.post && !boot_r) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
    if (cmd.post) begin
      out_h_r   <= (op_r == OP_READ && rd_ok_r) ? dp_h : '0;
      out_sat_r <= (op_r == OP_FAULT) ? dp_sat : 1'b0;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.height_value = out_h_r;
  assign out_ch.saturated    = out_sat_r;
endmodule
